/* rtl/ttc_pkg.sv */
// ----------------------------------------------------------------------------
// Thermistor temperature converter package
// Shared widths, fixed-point constants, register indexes and pipeline types.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int DEFAULT_FULL_SCALE  = 4095;
    localparam int DEFAULT_SAMPLE_BITS = 12;

    // Operand width of a log2 lane and the Q32 log2 result.
    localparam int LANE_W     = 24;
    localparam int LOG_INT_W  = 5;
    localparam int FRAC_BITS  = 32;
    localparam int LOG_W      = LOG_INT_W + FRAC_BITS;
    localparam int LOG_STAGES = FRAC_BITS + 1;

    // Datapath widths after the log2 lanes.
    localparam int S_W    = LOG_W + 2;
    localparam int MAG_W  = S_W - 1;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int LN_W   = 64;
    localparam int PP_W   = HALF_W + 32;
    localparam int LNQ_W  = MAG_W;
    localparam int P_W    = 54;
    localparam int Y_W    = 56;
    localparam int DIV_W  = Y_W - 1;
    localparam int Q_W    = 30;
    localparam int NUM_EXP = 76;
    localparam int CODE_W = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [LN_W-1:0] LN2_Q64     = 64'hB17217F7D1CF79AC;
    localparam logic [63:0]     Y0_Q56      = ((64'd20 << 56) + 64'd2981) / 64'd5963;
    localparam logic [63:0]     Y_FLOOR_Q56 = (64'd1 << 51) / 64'd25;
    localparam logic [31:0]     KELVIN_OFS_Q16 = 32'd286418534;
    localparam logic [31:0]     ROUND_HALF     = 32'd32768;
    localparam logic [31:0]     Q_SAT = KELVIN_OFS_Q16 + (32'd8191 << 16);

    localparam logic signed [CODE_W-1:0] CODE_MAX      = 14'sd8191;
    localparam logic signed [CODE_W-1:0] CODE_ABS_ZERO = -14'sd4370;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIXED_RES = 2'd0,
        REG_R25       = 2'd1,
        REG_INV_BETA  = 2'd2
    } cfg_reg_t;

    // Control bits that travel alongside each word in the pipeline.
    typedef struct packed {
        logic valid;
        logic endp;
        logic sat;
    } side_t;

endpackage

/* rtl/ttc_log2.sv */
// ----------------------------------------------------------------------------
// Pipelined log2 lane
// Normalises an unsigned operand, then resolves one fraction bit per stage by
// squaring the mantissa. Result is Q32 with the integer part above it.
// ----------------------------------------------------------------------------
module ttc_log2 import ttc_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [LANE_W-1:0] x,
    output logic [LOG_W-1:0]  log_q32
);

    logic [LOG_INT_W-1:0] n_reg [0:FRAC_BITS];
    logic [31:0]          m_reg [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] f_reg [0:FRAC_BITS];
    logic [LOG_INT_W-1:0] lead;

    always_comb begin
        lead = '0;
        for (int i = 0; i < LANE_W; i++) begin
            if (x[i]) begin
                lead = LOG_INT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0] <= lead;
            m_reg[0] <= 32'(x) << (LOG_INT_W'(31) - lead);
            f_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
        logic [63:0] sq;
        assign sq = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_reg[k-1];
                m_reg[k] <= sq[63] ? sq[63:32] : sq[62:31];
                f_reg[k] <= {f_reg[k-1][FRAC_BITS-2:0], sq[63]};
            end
        end
    end

    assign log_q32 = {n_reg[FRAC_BITS], f_reg[FRAC_BITS]};

endmodule

/* rtl/ttc_recip.sv */
// ----------------------------------------------------------------------------
// Pipelined reciprocal divider
// Restoring division of 2^76 by y, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ttc_recip import ttc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  side_t            in_side,
    input  logic [DIV_W-1:0] in_y,
    output side_t            out_side,
    output logic [Q_W-1:0]   out_q
);

    localparam logic [DIV_W-1:0] R_INIT = DIV_W'(1) << (NUM_EXP - Q_W);

    logic [DIV_W-1:0] r_reg    [0:Q_W];
    logic [DIV_W-1:0] y_reg    [0:Q_W];
    logic [Q_W-1:0]   q_reg    [0:Q_W];
    side_t            side_reg [0:Q_W];

    assign r_reg[0]    = R_INIT;
    assign y_reg[0]    = in_y;
    assign q_reg[0]    = '0;
    assign side_reg[0] = in_side;

    for (genvar j = 1; j <= Q_W; j++) begin : g_div
        logic [DIV_W:0] rs;
        logic           ge;
        logic [DIV_W:0] diff;
        assign rs   = {r_reg[j-1], 1'b0};
        assign ge   = rs >= {1'b0, y_reg[j-1]};
        assign diff = rs - {1'b0, y_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[j] <= '0;
            end else if (en) begin
                side_reg[j] <= side_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j] <= ge ? diff[DIV_W-1:0] : rs[DIV_W-1:0];
                y_reg[j] <= y_reg[j-1];
                q_reg[j] <= {q_reg[j-1][Q_W-2:0], ge};
            end
        end
    end

    assign out_side = side_reg[Q_W];
    assign out_q    = q_reg[Q_W];

endmodule

/* rtl/thermistor_temperature_converter.sv */
// ----------------------------------------------------------------------------
// Thermistor temperature converter
// NTC beta-equation converter: ADC word in, temperature in 1/16 degree C out.
// ----------------------------------------------------------------------------
// The block accepts one sample word in every clock cycle while the output
// buffer has room, and returns one result word per sample, in order. A sample
// passes through the 33-stage log2 lanes (one squaring per fraction bit), six
// stages of sum, multiply and reciprocal set-up, the 30-stage divider (one
// quotient bit per stage), a result stage and the output register. A two-deep
// output buffer lets the pipeline keep accepting while a result word waits.
// Configuration is written through cfg_valid/cfg_index/cfg_data, which is
// always ready; writes must only happen while no sample is in flight.
// ----------------------------------------------------------------------------
module thermistor_temperature_converter import ttc_pkg::*; #(
    parameter int FULL_SCALE  = DEFAULT_FULL_SCALE,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_raw_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [CODE_W-1:0] m_temperature,
    output logic                     m_in_range,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [LANE_W-1:0] rf_reg;
    logic [LANE_W-1:0] r25_reg;
    logic [31:0]       ib_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_reg  <= LANE_W'(10000);
            r25_reg <= LANE_W'(10000);
            ib_reg  <= 32'd278357374;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FIXED_RES: rf_reg  <= cfg_data[LANE_W-1:0];
                REG_R25:       r25_reg <= cfg_data[LANE_W-1:0];
                REG_INV_BETA:  ib_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the output buffer is full.
    logic en;
    logic skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Entry: the four log2 operands and the endpoint test.
    logic [LANE_W-1:0] raw_ext;
    logic [LANE_W-1:0] fs_minus_raw;
    logic              endp;

    assign raw_ext      = LANE_W'(s_raw_sample);
    assign fs_minus_raw = LANE_W'(FULL_SCALE) - raw_ext;
    assign endp = (raw_ext == '0) || (raw_ext >= LANE_W'(FULL_SCALE)) ||
                  (rf_reg == '0) || (r25_reg == '0);

    logic [LOG_W-1:0] log_r25;
    logic [LOG_W-1:0] log_rf;
    logic [LOG_W-1:0] log_top;
    logic [LOG_W-1:0] log_raw;

    ttc_log2 u_log_r25 (.aclk(aclk), .en(en), .x(r25_reg),      .log_q32(log_r25));
    ttc_log2 u_log_rf  (.aclk(aclk), .en(en), .x(rf_reg),       .log_q32(log_rf));
    ttc_log2 u_log_top (.aclk(aclk), .en(en), .x(fs_minus_raw), .log_q32(log_top));
    ttc_log2 u_log_raw (.aclk(aclk), .en(en), .x(raw_ext),      .log_q32(log_raw));

    // Control bits running alongside the log2 lanes.
    side_t side_log_reg [0:LOG_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_log_reg[0] <= '0;
        end else if (en) begin
            side_log_reg[0] <= '{valid: s_valid, endp: endp, sat: 1'b0};
        end
    end

    for (genvar k = 1; k < LOG_STAGES; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_log_reg[k] <= '0;
            end else if (en) begin
                side_log_reg[k] <= side_log_reg[k-1];
            end
        end
    end

    // Log ratio S and its magnitude.
    logic [S_W-1:0]   s_sum;
    logic [S_W-1:0]   s_neg_val;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_s_reg;
    side_t            side_s_reg;

    assign s_sum = S_W'(log_r25) - S_W'(log_rf) - S_W'(log_top) + S_W'(log_raw);
    assign s_neg_val = -s_sum;

    // Partial products of |S| times ln 2.
    logic [PP_W-1:0] pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
    logic            neg_m1_reg;
    side_t           side_m1_reg;

    // Natural log magnitude.
    localparam int FULL1_W = MAG_W + LN_W;
    logic [FULL1_W-1:0] prod1;
    logic [LNQ_W-1:0]   lnq_reg;
    logic               neg_m2_reg;
    side_t              side_m2_reg;

    assign prod1 = (FULL1_W'(pp_hh_reg) << (HALF_W + 32)) +
                   (FULL1_W'(pp_hl_reg) << HALF_W) +
                   (FULL1_W'(pp_lh_reg) << 32) +
                    FULL1_W'(pp_ll_reg);

    // Partial products of ln(R25/R) times the inverse beta.
    logic [PP_W-1:0] pb_h_reg, pb_l_reg;
    logic            neg_m3_reg;
    side_t           side_m3_reg;

    localparam int FULL2_W = LNQ_W + 32;
    logic [FULL2_W-1:0] prod2;
    logic [P_W-1:0]     p_reg;
    logic               neg_m4_reg;
    side_t              side_m4_reg;

    assign prod2 = (FULL2_W'(pb_h_reg) << HALF_W) + FULL2_W'(pb_l_reg);

    // Reciprocal temperature y in Q56 and the hot saturation test.
    logic [Y_W-1:0]   y_calc;
    logic             y_low;
    logic [DIV_W-1:0] y_reg;
    side_t            side_y_reg;

    assign y_calc = neg_m4_reg ? (Y_W'(Y0_Q56) + Y_W'(p_reg))
                               : (Y_W'(Y0_Q56) - Y_W'(p_reg));
    assign y_low  = $signed(y_calc) <= $signed(Y_W'(Y_FLOOR_Q56));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_s_reg  <= '0;
            side_m1_reg <= '0;
            side_m2_reg <= '0;
            side_m3_reg <= '0;
            side_m4_reg <= '0;
            side_y_reg  <= '0;
        end else if (en) begin
            side_s_reg  <= side_log_reg[LOG_STAGES-1];
            side_m1_reg <= side_s_reg;
            side_m2_reg <= side_m1_reg;
            side_m3_reg <= side_m2_reg;
            side_m4_reg <= side_m3_reg;
            side_y_reg  <= '{valid: side_m4_reg.valid, endp: side_m4_reg.endp, sat: y_low};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_s_reg  <= s_sum[S_W-1];
            mag_reg    <= s_sum[S_W-1] ? s_neg_val[MAG_W-1:0] : s_sum[MAG_W-1:0];

            pp_hh_reg  <= PP_W'(mag_reg[MAG_W-1:HALF_W]) * PP_W'(LN2_Q64[63:32]);
            pp_hl_reg  <= PP_W'(mag_reg[MAG_W-1:HALF_W]) * PP_W'(LN2_Q64[31:0]);
            pp_lh_reg  <= PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(LN2_Q64[63:32]);
            pp_ll_reg  <= PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(LN2_Q64[31:0]);
            neg_m1_reg <= neg_s_reg;

            lnq_reg    <= prod1[FULL1_W-1:LN_W];
            neg_m2_reg <= neg_m1_reg;

            pb_h_reg   <= PP_W'(lnq_reg[LNQ_W-1:HALF_W]) * PP_W'(ib_reg);
            pb_l_reg   <= PP_W'(lnq_reg[HALF_W-1:0]) * PP_W'(ib_reg);
            neg_m3_reg <= neg_m2_reg;

            p_reg      <= prod2[P_W+15:16];
            neg_m4_reg <= neg_m3_reg;

            y_reg      <= y_calc[DIV_W-1:0];
        end
    end

    // Reciprocal: q = 2^76 / y, which is sixteen times the absolute temperature in Q16.
    side_t          side_q;
    logic [Q_W-1:0] q;

    ttc_recip u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_side  (side_y_reg),
        .in_y     (y_reg),
        .out_side (side_q),
        .out_q    (q)
    );

    // Result stage: remove the kelvin offset with rounding, apply the limits.
    logic [31:0]              d_val;
    logic signed [CODE_W-1:0] code;
    logic                     ok;
    logic                     fin_valid_reg;
    logic signed [CODE_W-1:0] fin_temp_reg;
    logic                     fin_ok_reg;

    assign d_val = 32'(q) + ROUND_HALF - KELVIN_OFS_Q16;

    always_comb begin
        if (side_q.endp) begin
            code = CODE_ABS_ZERO;
            ok   = 1'b0;
        end else if (side_q.sat || (32'(q) >= Q_SAT)) begin
            code = CODE_MAX;
            ok   = 1'b0;
        end else begin
            code = d_val[CODE_W+15:16];
            ok   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= side_q.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_temp_reg <= code;
            fin_ok_reg   <= ok;
        end
    end

    // Output register with a skid entry behind it.
    logic                     m_valid_reg;
    logic signed [CODE_W-1:0] out_temp_reg, skid_temp_reg;
    logic                     out_ok_reg, skid_ok_reg;
    logic                     load_fin, load_skid, fill_skid;

    assign load_skid = skid_valid_reg && m_ready;
    assign load_fin  = !skid_valid_reg && fin_valid_reg && (!m_valid_reg || m_ready);
    assign fill_skid = !skid_valid_reg && fin_valid_reg && m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (load_skid) begin
                skid_valid_reg <= 1'b0;
            end else if (fill_skid) begin
                skid_valid_reg <= 1'b1;
            end
            if (load_fin || load_skid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_skid) begin
            out_temp_reg <= skid_temp_reg;
            out_ok_reg   <= skid_ok_reg;
        end else if (load_fin) begin
            out_temp_reg <= fin_temp_reg;
            out_ok_reg   <= fin_ok_reg;
        end
        if (fill_skid) begin
            skid_temp_reg <= fin_temp_reg;
            skid_ok_reg   <= fin_ok_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_temperature = out_temp_reg;
    assign m_in_range    = out_ok_reg;

endmodule

/* rtl/ttc_checker.sv */
// ----------------------------------------------------------------------------
// Thermistor temperature converter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ttc_checker import ttc_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [CODE_W-1:0] m_temperature,
    input logic                     m_in_range
);

    // No result word survives a reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature) && $stable(m_in_range))
        else $error("stalled result word changed");

    // A normal result lies between the two limit codes, both included, since
    // rounding just below the hot limit can land on the top code.
    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_range |-> (m_temperature >= CODE_ABS_ZERO) &&
                                  (m_temperature <= CODE_MAX))
        else $error("normal result outside the representable range");

    // An out-of-range flag only ever comes with one of the two limit codes.
    a_limit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> (m_temperature == CODE_MAX) ||
                                   (m_temperature == CODE_ABS_ZERO))
        else $error("out-of-range result without a limit code");

endmodule

bind thermistor_temperature_converter ttc_checker u_ttc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_temperature (m_temperature),
    .m_in_range    (m_in_range)
);
